// ===== rtl/pip_pkg.sv =====
// Package for the point-in-polygon crossing test.
// Request codes and the flag bundle passed from the edge front end to the top level.
// No dependencies.
package pip_pkg;

  // request codes carried on the input tuser
  localparam logic [1:0] REQ_QUERY  = 2'd0;
  localparam logic [1:0] REQ_RING   = 2'd1;
  localparam logic [1:0] REQ_VERTEX = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // per-edge status from the front end
  typedef struct packed {
    logic on_line;    // both ends lie on the query line
    logic span;       // query y strictly inside the edge's y span
    logic xmax_gt;    // larger edge x is right of the query x
    logic da_neg;     // lower end x is left of the query x
    logic db_neg;     // upper end x is left of the query x
    logic both_zero;  // both end x equal the query x
  } edge_flags_t;

endpackage

// ===== rtl/pip_edge_prep.sv =====
// Edge front end: orders the edge by y, forms offsets from the query point.
// Combinational; depends on pip_pkg.
module pip_edge_prep
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  output edge_flags_t                  flags,
  output logic        [COORD_BITS:0]   mag_a,
  output logic        [COORD_BITS:0]   mag_b,
  output logic        [COORD_BITS:0]   dy_a,
  output logic        [COORD_BITS:0]   dy_b
);

  logic                         swap;
  logic signed [COORD_BITS-1:0] xa, ya, xb, yb, xmax;
  logic signed [COORD_BITS:0]   da, db;

  // order the ends so that (xa, ya) is the lower one
  always_comb begin
    swap = y0 > y1;
    xa   = swap ? x1 : x0;
    ya   = swap ? y1 : y0;
    xb   = swap ? x0 : x1;
    yb   = swap ? y0 : y1;
    xmax = (xa > xb) ? xa : xb;
  end

  // offsets from the query point, one bit wider than a coordinate
  always_comb begin
    da = {xa[COORD_BITS-1], xa} - {qx[COORD_BITS-1], qx};
    db = {xb[COORD_BITS-1], xb} - {qx[COORD_BITS-1], qx};
    mag_a = da[COORD_BITS] ? '0 - da : da;
    mag_b = db[COORD_BITS] ? '0 - db : db;
    // only meaningful when the span flag is set; then both are positive
    dy_b = {yb[COORD_BITS-1], yb} - {qy[COORD_BITS-1], qy};
    dy_a = {qy[COORD_BITS-1], qy} - {ya[COORD_BITS-1], ya};
  end

  // status flags
  always_comb begin
    flags.on_line   = (y0 == qy) && (y1 == qy);
    flags.span      = (qy > ya) && (qy < yb);
    flags.xmax_gt   = xmax > qx;
    flags.da_neg    = da[COORD_BITS];
    flags.db_neg    = db[COORD_BITS];
    flags.both_zero = (da == '0) && (db == '0);
  end

endmodule

// ===== rtl/point_in_polygon_test_top.sv =====
// Channel  Dir  tvalid/tready        tdata (low bit up)                 side bands
// s_axis   in   s_axis_tvalid/tready x_coord, y_coord                   tuser=req_type, tlast=last_vertex
// m_axis   out  m_axis_tvalid/tready inside_res, crossing_count, zeros  none
//
// One item per cycle sustained while no result is stalled; an item that ends a polygon
// shows its result once it has passed the stage 1, stage 2 and product registers, then the output.
// The rate is set by the three-stage edge pipeline, each stage moving every cycle unless a stalled result holds it.
// rst (synchronous) clears the query point, the previous vertex, the tally and all valids.
// A stalled result holds only its own stage; items that give no result keep draining
// and new items are taken while any pipeline stage is free.
module point_in_polygon_test_top
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // x_coord [COORD_BITS-1:0], y_coord above it, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
  // req_type [1:0]
  input  logic [1:0]                                 s_axis_tuser,
  input  logic                                       s_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // inside_res [0], crossing_count [COUNT_BITS:1], zero fill
  output logic [((COUNT_BITS+1+7)/8)*8-1:0]          m_axis_tdata
);

  localparam int PROD_BITS = 2 * (COORD_BITS + 1);

  // architectural state
  logic signed [COORD_BITS-1:0] query_px, query_py, prev_vx, prev_vy;
  logic        [COUNT_BITS-1:0] cross_tally, cross_tally_next;

  // stage 1: input register
  logic                         v1, s1_last;
  logic [1:0]                   s1_kind;
  logic signed [COORD_BITS-1:0] s1_x, s1_y, s1_px, s1_py, s1_qx, s1_qy;

  // stage 2: edge front end results
  logic                         v2, s2_last;
  logic [1:0]                   s2_kind;
  edge_flags_t                  s2_flags, prep_flags;
  logic [COORD_BITS:0]          s2_mag_a, s2_mag_b, s2_dy_a, s2_dy_b;
  logic [COORD_BITS:0]          prep_mag_a, prep_mag_b, prep_dy_a, prep_dy_b;

  // stage 3: products
  logic                         v3, s3_last;
  logic [1:0]                   s3_kind;
  edge_flags_t                  s3_flags;
  logic [PROD_BITS-1:0]         s3_p, s3_q;

  logic                         out_valid;
  logic [COUNT_BITS-1:0]        out_count;

  logic                         in_acc, out_free, rdy1, rdy2, rdy3, adv3, hit;
  logic signed [COORD_BITS-1:0] in_x, in_y;

  assign in_x = s_axis_tdata[COORD_BITS-1:0];
  assign in_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  // ready chain: a stage loads when it is empty or its item moves on
  always_comb begin
    out_free = !out_valid || m_axis_tready;
    rdy3     = !v3 || !s3_last || out_free;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    adv3     = v3 && rdy3;
  end

  assign s_axis_tready = rdy1;
  assign in_acc        = s_axis_tvalid && rdy1;

  // query point and previous vertex follow items as they are taken
  always_ff @(posedge clk) begin
    if (rst) begin
      query_px <= '0;
      query_py <= '0;
      prev_vx  <= '0;
      prev_vy  <= '0;
    end else if (in_acc) begin
      unique case (s_axis_tuser)
        REQ_QUERY: begin
          query_px <= in_x;
          query_py <= in_y;
        end
        REQ_RING, REQ_VERTEX: begin
          prev_vx <= in_x;
          prev_vy <= in_y;
        end
        default: ;
      endcase
    end
  end

  // stage 1 register; unused request codes are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_acc && (s_axis_tuser != REQ_UNUSED);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_kind <= s_axis_tuser;
      s1_last <= s_axis_tlast;
      s1_x    <= in_x;
      s1_y    <= in_y;
      s1_px   <= prev_vx;
      s1_py   <= prev_vy;
      s1_qx   <= query_px;
      s1_qy   <= query_py;
    end
  end

  pip_edge_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .qx    (s1_qx),
    .qy    (s1_qy),
    .x0    (s1_px),
    .y0    (s1_py),
    .x1    (s1_x),
    .y1    (s1_y),
    .flags (prep_flags),
    .mag_a (prep_mag_a),
    .mag_b (prep_mag_b),
    .dy_a  (prep_dy_a),
    .dy_b  (prep_dy_b)
  );

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_kind  <= s1_kind;
      s2_last  <= s1_last;
      s2_flags <= prep_flags;
      s2_mag_a <= prep_mag_a;
      s2_mag_b <= prep_mag_b;
      s2_dy_a  <= prep_dy_a;
      s2_dy_b  <= prep_dy_b;
    end
  end

  // stage 3: the two cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_kind  <= s2_kind;
      s3_last  <= s2_last;
      s3_flags <= s2_flags;
      s3_p     <= s2_mag_a * s2_dy_b;
      s3_q     <= s2_mag_b * s2_dy_a;
    end
  end

  // crossing decision: sign of (xa-px)(yb-py) + (xb-px)(py-ya)
  always_comb begin
    hit = 1'b0;
    if (s3_kind == REQ_VERTEX) begin
      if (s3_flags.on_line) begin
        hit = 1'b1;
      end else if (s3_flags.span && s3_flags.xmax_gt) begin
        priority if (!s3_flags.da_neg && !s3_flags.db_neg) begin
          hit = !s3_flags.both_zero;
        end else if (s3_flags.da_neg && s3_flags.db_neg) begin
          hit = 1'b0;
        end else if (s3_flags.da_neg) begin
          hit = s3_q > s3_p;
        end else begin
          hit = s3_p > s3_q;
        end
      end
    end
    cross_tally_next = (s3_kind == REQ_QUERY) ? '0 : cross_tally + COUNT_BITS'(hit);
  end

  // tally and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_tally <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (adv3) begin
        cross_tally <= cross_tally_next;
      end
      if (adv3 && s3_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s3_last) begin
      out_count <= cross_tally_next;
    end
  end

  // result packing
  assign m_axis_tvalid = out_valid;
  always_comb begin
    m_axis_tdata               = '0;
    m_axis_tdata[0]            = out_count[0];
    m_axis_tdata[COUNT_BITS:1] = out_count;
  end

endmodule

// ===== rtl/pip_checker.sv =====
// Port-level checks for the point-in-polygon test, bound to the top level.
// Depends on point_in_polygon_test_top port names and its COUNT_BITS parameter only.
module pip_port_checks #(
  parameter int COUNT_BITS = 16
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((COUNT_BITS+1+7)/8)*8-1:0]    m_axis_tdata
);

  // a result waiting for its taker keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the inside flag is the parity of the count
  a_parity: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[0] == m_axis_tdata[1])
    else $error("inside flag disagrees with count parity");

  // input stalls only when the pipeline is full behind a stalled result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // an offered item stays offered until it is taken
  a_offer: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
    else $error("input item withdrawn before it was taken");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind point_in_polygon_test_top pip_port_checks #(
  .COUNT_BITS(COUNT_BITS)
) u_pip_port_checks (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/pip_checker.sv =====
// Checker for the point-in-polygon crossing test: watches both stream channels, tracks the
// query point, previous vertex and crossing tally, and compares each result in order.
// Depends on pip_pkg for the request codes.
`timescale 1ns / 1ps

module pip_checker
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input  logic [1:0]                           s_axis_tuser,
  input  logic                                 s_axis_tlast,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic [((COUNT_BITS+1+7)/8)*8-1:0]    m_axis_tdata,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   results_seen
);

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  // wide enough for the sum of two products of 33-bit differences
  typedef logic signed [2*COORD_BITS+3:0] wide_t;

  typedef struct {
    logic                  parity;
    logic [COUNT_BITS-1:0] count;
  } tally_t;

  coord_t                query_x = '0;
  coord_t                query_y = '0;
  coord_t                prev_x  = '0;
  coord_t                prev_y  = '0;
  logic [COUNT_BITS-1:0] tally   = '0;
  tally_t                expected_tallies[$];
  int                    err_count = 0;
  int                    got_count = 0;
  int                    waiting   = 0;

  assign mismatches   = err_count;
  assign pending      = waiting;
  assign results_seen = got_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("%0t pip_checker: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Does the edge (x0,y0)-(x1,y1) count a crossing of the ray from the query point?
  function automatic bit edge_crosses(input coord_t x0, input coord_t y0,
                                      input coord_t x1, input coord_t y1);
    coord_t xa, ya, xb, yb, xmax;
    wide_t  wxa, wya, wxb, wyb, wpx, wpy, side;
    if (y0 == query_y && y1 == query_y)
      return 1'b1;
    if (y0 <= y1) begin
      xa = x0; ya = y0; xb = x1; yb = y1;
    end else begin
      xa = x1; ya = y1; xb = x0; yb = y0;
    end
    if (!(query_y > ya && query_y < yb))
      return 1'b0;
    xmax = (xa > xb) ? xa : xb;
    if (!(xmax > query_x))
      return 1'b0;
    // crossing x right of query x, scaled by the positive y span
    wxa = xa; wya = ya; wxb = xb; wyb = yb; wpx = query_x; wpy = query_y;
    side = (wxa - wpx) * (wyb - wpy) + (wxb - wpx) * (wpy - wya);
    return side > 0;
  endfunction

  // Update state for one accepted item and queue its result, if any
  task automatic apply_item(input logic [1:0] kind, input coord_t x, input coord_t y,
                            input logic last);
    tally_t res;
    if (kind == REQ_UNUSED)
      return;
    if (kind == REQ_QUERY) begin
      query_x = x;
      query_y = y;
      tally   = '0;
    end else begin
      if (kind == REQ_VERTEX && edge_crosses(prev_x, prev_y, x, y))
        tally = tally + 1'b1;
      prev_x = x;
      prev_y = y;
    end
    if (last) begin
      res.parity = tally[0];
      res.count  = tally;
      expected_tallies.push_back(res);
    end
  endtask

  // Results are checked before the item of the same edge is applied
  always @(posedge clk) begin : watch
    tally_t want;
    if (rst) begin
      query_x = '0;
      query_y = '0;
      prev_x  = '0;
      prev_y  = '0;
      tally   = '0;
      expected_tallies.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_count++;
        if (expected_tallies.size() == 0) begin
          report_mismatch("result with nothing expected", int'(m_axis_tdata[COUNT_BITS:1]), -1);
        end else begin
          want = expected_tallies.pop_front();
          if (m_axis_tdata[0] !== want.parity)
            report_mismatch("inside_res", int'(m_axis_tdata[0]), int'(want.parity));
          if (m_axis_tdata[COUNT_BITS:1] !== want.count)
            report_mismatch("crossing_count", int'(m_axis_tdata[COUNT_BITS:1]),
                            int'(want.count));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_item(s_axis_tuser, s_axis_tdata[COORD_BITS-1:0],
                   s_axis_tdata[2*COORD_BITS-1:COORD_BITS], s_axis_tlast);
    end
    waiting = expected_tallies.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the point-in-polygon crossing test bench: clock, reset, item stimulus and verdict.
// Instantiates point_in_polygon_test_top and pip_checker; uses pip_pkg for request codes.
`timescale 1ns / 1ps

module tb_top;
  import pip_pkg::*;

  localparam int COORD_BITS   = 32;
  localparam int COUNT_BITS   = 16;
  localparam int IN_W         = ((2*COORD_BITS+7)/8)*8;
  localparam int OUT_W        = ((COUNT_BITS+1+7)/8)*8;
  localparam int RANDOM_ITEMS = 1020;
  localparam int DRAIN_EVERY  = 40;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef enum {SHAPE_SMALL, SHAPE_FULL, SHAPE_EXTREME, SHAPE_MIXED} shape_e;
  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BLOCKS} rx_mode_e;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = REQ_QUERY;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int mismatches, pending, results_seen;
  int burst_left    = 0;
  int applied_items = 0;
  int ignored_items = 0;
  int polygons      = 0;

  always #1 clk = ~clk;

  point_in_polygon_test_top #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pip_checker #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) tally_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Receiver stall pattern: switches between randomly chosen modes
  rx_mode_e rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       stall_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Drive one item at a falling edge and hold it until accepted; bursts with random gaps
  task automatic send_item(input logic [1:0] kind, input coord_t x, input coord_t y,
                           input logic last);
    int              gap;
    logic [IN_W-1:0] word;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 16);
    end
    word = '0;
    word[COORD_BITS-1:0]            = x;
    word[2*COORD_BITS-1:COORD_BITS] = y;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0)
      burst_left--;
    if (kind == REQ_UNUSED)
      ignored_items++;
    else
      applied_items++;
  endtask

  // Stop sending until every expected result is back, plus pipeline depth
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic coord_t coord_for(input shape_e shape, input coord_t near);
    shape_e pick;
    pick = (shape == SHAPE_MIXED) ? shape_e'($urandom_range(0, 2)) : shape;
    case (pick)
      SHAPE_SMALL: return near + coord_t'(int'($urandom_range(0, 16)) - 8);
      SHAPE_FULL:  return coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 6))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return coord_t'(0);
          3:       return coord_t'(-1);
          4:       return near;
          5:       return near + coord_t'(1);
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Query, then one or two rings, the final vertex carrying the last mark
  task automatic send_polygon();
    shape_e shape;
    coord_t qx, qy, fx, fy, x, y;
    int     rings, n;
    bit     closed;
    shape = shape_e'($urandom_range(0, 3));
    qx = coord_for(shape, coord_t'(0));
    qy = coord_for(shape, coord_t'(0));
    send_item(REQ_QUERY, qx, qy, 1'b0);
    rings = ($urandom_range(0, 3) == 0) ? 2 : 1;
    for (int r = 0; r < rings; r++) begin
      n      = $urandom_range(2, 10);
      closed = ($urandom_range(0, 3) != 0);
      fx = coord_for(shape, qx);
      fy = coord_for(shape, qy);
      send_item(REQ_RING, fx, fy, 1'b0);
      for (int i = 0; i < n; i++) begin
        x = coord_for(shape, qx);
        y = coord_for(shape, qy);
        send_item(REQ_VERTEX, x, y, (r == rings - 1) && !closed && (i == n - 1));
      end
      if (closed)
        send_item(REQ_VERTEX, fx, fy, r == rings - 1);
    end
    polygons++;
  endtask

  // Stray item of any code, random content and last mark
  task automatic send_noise();
    logic [1:0] kind;
    kind = 2'($urandom_range(0, 3));
    send_item(kind, coord_t'($urandom), coord_t'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unused code with last set, then edges from the reset vertex with no ring start
    send_item(REQ_UNUSED, COORD_MAX, COORD_MIN, 1'b1);
    send_item(REQ_VERTEX, 3, -4, 1'b0);
    send_item(REQ_VERTEX, -2, 4, 1'b1);
    // last mark on a query and on a ring start
    send_item(REQ_QUERY, 0, 0, 1'b1);
    send_item(REQ_RING, -10, -10, 1'b1);
    send_item(REQ_VERTEX, 10, -10, 1'b0);
    send_item(REQ_VERTEX, 10, 10, 1'b0);
    send_item(REQ_VERTEX, -10, 10, 1'b0);
    send_item(REQ_VERTEX, -10, -10, 1'b1);
    // edges lying on the query line
    send_item(REQ_QUERY, 0, 5, 1'b0);
    send_item(REQ_RING, -3, 5, 1'b0);
    send_item(REQ_VERTEX, 7, 5, 1'b0);
    send_item(REQ_VERTEX, 7, -5, 1'b0);
    send_item(REQ_VERTEX, -3, 5, 1'b1);
    // full-scale square around the origin
    send_item(REQ_QUERY, 0, 0, 1'b0);
    send_item(REQ_RING, COORD_MAX, COORD_MIN, 1'b0);
    send_item(REQ_VERTEX, COORD_MAX, COORD_MAX, 1'b0);
    send_item(REQ_VERTEX, COORD_MIN, COORD_MAX, 1'b0);
    send_item(REQ_VERTEX, COORD_MIN, COORD_MIN, 1'b0);
    send_item(REQ_VERTEX, COORD_MAX, COORD_MIN, 1'b1);
    // query at the top corner
    send_item(REQ_QUERY, COORD_MAX, COORD_MAX, 1'b0);
    send_item(REQ_RING, COORD_MIN, COORD_MIN, 1'b0);
    send_item(REQ_VERTEX, COORD_MAX, COORD_MAX, 1'b0);
    send_item(REQ_VERTEX, COORD_MIN, COORD_MAX, 1'b1);
    // crossing exactly at the query point does not count
    send_item(REQ_QUERY, 0, 0, 1'b0);
    send_item(REQ_RING, -1, -1, 1'b0);
    send_item(REQ_VERTEX, 1, 1, 1'b1);
    drain_results();

    // random polygons with some stray items mixed in
    start = applied_items;
    while (applied_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
      end else begin
        send_polygon();
        if (polygons % DRAIN_EVERY == 0)
          drain_results();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("tb_top: %0d items applied: corner cases plus %0d random polygons",
             applied_items, polygons);
    $display("tb_top: %0d results compared, %0d unused-code items, %0d mismatches",
             results_seen, ignored_items, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pip_pkg.sv
rtl/pip_edge_prep.sv
rtl/point_in_polygon_test_top.sv
rtl/pip_checker.sv
test/pip_checker.sv
test/tb_top.sv
